// File: sv/fevd_pkg.sv
// Shared widths and defaults for the frame energy voice detector.
package fevd_pkg;

  // Default frame length limit, in samples
  localparam int MAX_FRAME_SAMPLES_DEF = 4096;
  // Entries in the frame record queue between front and back
  localparam int QUEUE_DEPTH_DEF       = 2;

  // Fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int SQUARE_W  = 31;  // 32768^2 = 2^30 fits
  localparam int PEAK_W    = 15;
  localparam int THR_W     = 31;
  localparam int MEAN_W    = 31;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 48; // mean, voice, peak, too_long

  // Largest magnitude reported as peak
  localparam logic [PEAK_W-1:0] PEAK_SAT = {PEAK_W{1'b1}};

endpackage

// File: sv/fevd_front.sv
// Front part: sample magnitude/square stage and per-frame accumulators.
module fevd_front import fevd_pkg::*; #(
  parameter int MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF,
  parameter int CNT_W             = $clog2(MAX_FRAME_SAMPLES + 1),
  parameter int SUM_W             = SQUARE_W - 1 + CNT_W,
  parameter int REC_W             = SUM_W + CNT_W + PEAK_W + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                last_i,
  output logic                rec_valid_o,
  input  logic                rec_full_i,
  output logic [REC_W-1:0]    rec_o        // {too_long, peak, count, sum}
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_SAMPLES);

  logic                s1_valid_q;
  logic [SQUARE_W-1:0] s1_sq_q;
  logic [PEAK_W-1:0]   s1_pk_q;
  logic                s1_last_q;
  logic                s1_fire;
  logic                in_fire;

  logic [SAMPLE_W-1:0] mag;
  logic [2*SAMPLE_W-1:0] mag_sq;

  logic [SUM_W-1:0]  sum_q, sum_n;
  logic [CNT_W-1:0]  cnt_q, cnt_n;
  logic [PEAK_W-1:0] peak_q, peak_n;
  logic              ovf_q, ovf_n;

  // Magnitude of the sample; -32768 gives 32768 as unsigned
  always_comb begin
    mag    = sample_i[SAMPLE_W-1] ? (SAMPLE_W'(0) - sample_i) : sample_i;
    mag_sq = (2*SAMPLE_W)'(mag) * (2*SAMPLE_W)'(mag);
  end

  // A last beat may only move on when the queue has room
  assign s1_fire    = s1_valid_q && (!s1_last_q || !rec_full_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // Stage 1: registered square and saturated peak candidate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_sq_q   <= mag_sq[SQUARE_W-1:0];
      s1_pk_q   <= mag[SAMPLE_W-1] ? PEAK_SAT : mag[PEAK_W-1:0];
      s1_last_q <= last_i;
    end
  end

  // Accumulator update; samples past the limit only set the overflow flag
  always_comb begin
    sum_n  = sum_q;
    cnt_n  = cnt_q;
    peak_n = peak_q;
    ovf_n  = ovf_q;
    if (cnt_q < MAX_CNT) begin
      sum_n  = sum_q + SUM_W'(s1_sq_q);
      cnt_n  = cnt_q + CNT_W'(1);
      if (s1_pk_q > peak_q) begin
        peak_n = s1_pk_q;
      end
    end else begin
      ovf_n = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      peak_q <= '0;
      ovf_q  <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last_q) begin
        sum_q  <= '0;
        cnt_q  <= '0;
        peak_q <= '0;
        ovf_q  <= 1'b0;
      end else begin
        sum_q  <= sum_n;
        cnt_q  <= cnt_n;
        peak_q <= peak_n;
        ovf_q  <= ovf_n;
      end
    end
  end

  // Frame record goes to the queue on the last beat
  assign rec_valid_o = s1_fire && s1_last_q;
  assign rec_o       = {ovf_n, peak_n, cnt_n, sum_n};

endmodule

// File: sv/fevd_queue.sv
// Short register queue for frame records between front and back.
module fevd_queue import fevd_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

// File: sv/fevd_back.sv
// Back part: bit-serial mean division, threshold compare, output register.
module fevd_back import fevd_pkg::*; #(
  parameter int MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF,
  parameter int CNT_W             = $clog2(MAX_FRAME_SAMPLES + 1),
  parameter int SUM_W             = SQUARE_W - 1 + CNT_W,
  parameter int REC_W             = SUM_W + CNT_W + PEAK_W + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rec_valid_i,
  output logic                  rec_pop_o,
  input  logic [REC_W-1:0]      rec_i,       // {too_long, peak, count, sum}
  input  logic [THR_W-1:0]      thr_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  localparam int PROD_W = THR_W + CNT_W;
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_q;
  logic [SUM_W-1:0]  quo_q;      // dividend shifts out, quotient shifts in
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  rem_q, div_q, rem_d;
  logic [PROD_W-1:0] prod_q;
  logic [PEAK_W-1:0] peak_q;
  logic              ovf_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W:0]    trial, trial_sub;
  logic              ge;

  logic              out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic              load_out;

  logic [SUM_W-1:0]  rec_sum;
  logic [CNT_W-1:0]  rec_cnt;
  logic [PEAK_W-1:0] rec_peak;
  logic              rec_ovf;

  assign {rec_ovf, rec_peak, rec_cnt, rec_sum} = rec_i;

  // One restoring step per cycle
  always_comb begin
    trial     = {rem_q, quo_q[SUM_W-1]};
    trial_sub = trial - {1'b0, div_q};
    ge        = (trial >= {1'b0, div_q});
    rem_d     = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  assign rec_pop_o = (state_q == ST_IDLE) && rec_valid_i;
  assign load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (rec_valid_i) begin
            state_q <= ST_RUN;
            step_q  <= '0;
          end
        end
        ST_RUN: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(SUM_W - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath: load a record, then shift the division
  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      quo_q  <= rec_sum;
      sum_q  <= rec_sum;
      div_q  <= rec_cnt;
      rem_q  <= '0;
      prod_q <= PROD_W'(thr_i) * PROD_W'(rec_cnt);
      peak_q <= rec_peak;
      ovf_q  <= rec_ovf;
    end else if (state_q == ST_RUN) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[SUM_W-2:0], ge};
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= {ovf_q, peak_q, (PROD_W'(sum_q) > prod_q), quo_q[MEAN_W-1:0]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: sv/frame_energy_voice_detector_unit.sv
// Top level of the frame energy voice detector.
//
//   channel   dir  beat contents
//   s_axis    in   tdata[15:0] sample (signed), tlast = last sample of frame
//   m_axis    out  tdata: [30:0] mean_energy, [31] voice_active,
//                  [46:32] peak_amplitude, [47] frame_too_long
//   cfg       in   cfg_data_i[30:0] energy_threshold
//
// The front takes one sample per cycle; a full queue holds the last beat of
// a frame, which stalls s_axis. A sample is registered in stage 1 before it
// reaches the accumulators. The back pops one frame record at a time and no
// other until its result is in the output register; its divider forms one
// quotient bit per cycle, and a two-entry record queue lets the next frames
// accumulate meanwhile. Reset clears all control state and the accumulators.
module frame_energy_voice_detector_unit import fevd_pkg::*; #(
  parameter int MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF,
  parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] sample
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // mean, voice, peak, too_long
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [THR_W-1:0]      cfg_data_i
);

  localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SUM_W = SQUARE_W - 1 + CNT_W;
  localparam int REC_W = SUM_W + CNT_W + PEAK_W + 1;

  logic [THR_W-1:0] thr_q;
  logic             q_push, q_full, q_pop, q_valid;
  logic [REC_W-1:0] q_in, q_out;

  // Threshold register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  fevd_front #(
    .MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES),
    .CNT_W(CNT_W),
    .SUM_W(SUM_W),
    .REC_W(REC_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sample_i   (s_axis_tdata[SAMPLE_W-1:0]),
    .last_i     (s_axis_tlast),
    .rec_valid_o(q_push),
    .rec_full_i (q_full),
    .rec_o      (q_in)
  );

  fevd_queue #(
    .W    (REC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_in),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_out)
  );

  fevd_back #(
    .MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES),
    .CNT_W(CNT_W),
    .SUM_W(SUM_W),
    .REC_W(REC_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_valid_i(q_valid),
    .rec_pop_o  (q_pop),
    .rec_i      (q_out),
    .thr_i      (thr_q),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

  // Checks
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("frame record pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_valid |-> !q_pop)
    else $error("frame record popped from empty queue");

  a_mean_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[MEAN_W-1]) |-> (m_axis_tdata[MEAN_W-2:0] == '0))
    else $error("mean energy above 2^30");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the frame energy voice detector.
module testbench;
  import fevd_pkg::*;

  localparam int FRAME_LIMIT  = MAX_FRAME_SAMPLES_DEF;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT  = 4000;  // cycles without any beat
  localparam int SHORT_ITEMS  = 650;
  localparam int RAND_PHASES  = 5;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } pcm_beat_t;

  // Same layout as m_axis_tdata, lowest field last
  typedef struct packed {
    logic              too_long;
    logic [PEAK_W-1:0] peak;
    logic              voice;
    logic [MEAN_W-1:0] mean;
  } frame_report_t;

  typedef enum int { FILL_UNIFORM, FILL_QUIET, FILL_EXTREME, FILL_CONST } fill_kind_e;
  typedef enum int { RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE } rx_mode_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [15:0] sample
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // mean, voice, peak, too_long
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [THR_W-1:0]      cfg_data_i    = '0;

  // Frame accumulator copy and threshold as seen by the block
  logic [THR_W-1:0]  thr_model    = '0;
  logic [42:0]       acc_sum      = '0;
  logic [12:0]       acc_count    = '0;
  logic [PEAK_W-1:0] acc_peak     = '0;
  logic              acc_overflow = 1'b0;

  frame_report_t reports_due[$];
  pcm_beat_t     samples_pending[$];
  pcm_beat_t     beat_on_bus;

  int unsigned samples_queued  = 0;
  int unsigned samples_taken   = 0;
  int unsigned reports_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned cfg_writes      = 0;

  frame_energy_voice_detector_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4;
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
  end

  // Fold one accepted sample into the frame; on the last beat form the report
  function automatic void absorb_sample(pcm_beat_t b);
    int                smp;
    int unsigned       mag;
    logic [PEAK_W-1:0] clipped;
    longint unsigned   bound;
    frame_report_t     r;
    smp = $signed(b.sample);
    mag = (smp < 0) ? -smp : smp;
    if (acc_count < FRAME_LIMIT) begin
      clipped   = (mag > PEAK_SAT) ? PEAK_SAT : PEAK_W'(mag);
      acc_sum   = acc_sum + 43'(mag) * 43'(mag);
      acc_count = acc_count + 1'b1;
      if (clipped > acc_peak) acc_peak = clipped;
    end else begin
      acc_overflow = 1'b1;   // past the limit: sample ignored
    end
    if (b.last) begin
      bound      = 64'(thr_model);
      bound      = bound * acc_count;
      r.mean     = MEAN_W'(acc_sum / acc_count);
      r.voice    = (64'(acc_sum) > bound);
      r.peak     = acc_peak;
      r.too_long = acc_overflow;
      reports_due = {reports_due, r};
      acc_sum      = '0;
      acc_count    = '0;
      acc_peak     = '0;
      acc_overflow = 1'b0;
    end
  endfunction

  function automatic void queue_beat(logic [SAMPLE_W-1:0] smp, logic last);
    pcm_beat_t b;
    b.sample = smp;
    b.last   = last;
    samples_pending = {samples_pending, b};
    samples_queued++;
  endfunction

  function automatic void queue_frame(int len, fill_kind_e kind, logic [SAMPLE_W-1:0] level);
    logic [SAMPLE_W-1:0] extremes[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h8001};
    logic [SAMPLE_W-1:0] smp;
    int                  amp;
    amp = $urandom_range(1, 32768);
    for (int i = 0; i < len; i++) begin
      case (kind)
        FILL_UNIFORM: smp = SAMPLE_W'($urandom);
        FILL_QUIET:   smp = SAMPLE_W'(int'($urandom_range(0, 2 * amp)) - amp);
        FILL_EXTREME: smp = extremes[2'($urandom_range(0, 3))];
        default:      smp = level;
      endcase
      queue_beat(smp, i == len - 1);
    end
  endfunction

  function automatic void flag_field(string what, longint unsigned want, longint unsigned got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
  endfunction

  // Block is idle only when every sample went in and every report came out
  task automatic wait_drained();
    while (samples_taken != samples_queued || reports_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    thr_model = value;
    cfg_writes++;
  endtask

  // Sample driver: bursts of random length, some separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_sample(beat_on_bus);
        samples_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (samples_pending.size() > 0) begin
          beat_on_bus = samples_pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= beat_on_bus.sample;
          s_axis_tlast  <= beat_on_bus.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Report monitor; ready follows a mode that is redrawn at random
  rx_mode_e    rx_mode  = RX_OPEN;
  int          rx_left  = 0;
  int unsigned rx_phase = 0;
  always @(posedge clk_i) begin
    frame_report_t got;
    frame_report_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        reports_checked++;
        if (reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("report with no frame pending: 0x%0h", got);
        end else begin
          want = reports_due.pop_front();
          if (got.mean !== want.mean)         flag_field("mean_energy", want.mean, got.mean);
          if (got.voice !== want.voice)       flag_field("voice_active", want.voice, got.voice);
          if (got.peak !== want.peak)         flag_field("peak_amplitude", want.peak, got.peak);
          if (got.too_long !== want.too_long) flag_field("frame_too_long", want.too_long,
                                                         got.too_long);
        end
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(RX_OPEN, RX_CADENCE));
        rx_left = $urandom_range(16, 128);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 4) == 0);
        default:   m_axis_tready <= (rx_phase % 8) < 3;
      endcase
    end
  end

  // Watchdog on cycles in which no beat moves on any channel
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int               phase_items;
    int               len;
    int unsigned      root;
    logic [THR_W-1:0] thr;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames at the reset threshold of zero
    queue_beat(16'h0000, 1'b1);   // silence: energy not above zero
    queue_beat(16'h8000, 1'b1);   // most negative sample: peak saturates
    queue_beat(16'h7FFF, 1'b1);
    queue_beat(16'h8001, 1'b1);
    queue_beat(16'h0001, 1'b0);
    queue_beat(16'hFFFF, 1'b0);
    queue_beat(16'h5555, 1'b0);
    queue_beat(16'hAAAA, 1'b1);
    wait_drained();

    // Strict compare: energy equal to the threshold is not voice
    write_threshold(31'd10000);
    queue_frame(4, FILL_CONST, 16'sd100);
    queue_frame(3, FILL_CONST, -16'sd100);
    queue_frame(1, FILL_CONST, 16'sd101);
    queue_frame(2, FILL_CONST, 16'sd99);
    wait_drained();

    // Random frames under several thresholds, all bits low and high among them
    for (int p = 0; p < RAND_PHASES; p++) begin
      root = $urandom_range(0, 32767);
      thr  = (p == 1) ? '0 : (p == 3) ? '1 : THR_W'(root * root);
      write_threshold(thr);
      phase_items = 0;
      while (phase_items < SHORT_ITEMS / RAND_PHASES) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        queue_frame(len, fill_kind_e'($urandom_range(FILL_UNIFORM, FILL_CONST)),
                    SAMPLE_W'($urandom));
        phase_items += len;
      end
      wait_drained();
    end

    // Full-length frame of the largest square: sum equals threshold times count
    write_threshold(31'h4000_0000);
    queue_frame(FRAME_LIMIT, FILL_CONST, 16'h8000);
    queue_beat(16'h8000, 1'b1);
    wait_drained();

    // Frames past the limit; late loud samples must not reach peak or sum
    write_threshold(31'h3FFF_FFFF);
    queue_frame(FRAME_LIMIT + 1, FILL_CONST, 16'h8000);
    for (int i = 0; i < FRAME_LIMIT + 8; i++)
      queue_beat((i < FRAME_LIMIT) ? SAMPLE_W'($urandom_range(0, 200)) : 16'h8000,
                 i == FRAME_LIMIT + 7);
    queue_frame(3, FILL_UNIFORM, '0);   // overflow flag must be clear again
    wait_drained();

    $display("Ran %0d samples in %0d frames under %0d threshold writes,",
             samples_taken, reports_checked, cfg_writes);
    $display("including frames at and beyond the %0d-sample limit; %0d mismatches.",
             FRAME_LIMIT, mismatches);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
